[hw/rtl/msort_pkg.sv]
`timescale 1ns / 1ps

package msort_pkg;

    localparam int VALUE_BITS = 32;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } s_beat_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last_res;
    } m_beat_t;

    // Per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic load_en;   // insert the broadcast value into the sorted row
        logic shift_en;  // advance the row one place toward cell 0
    } msort_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } msort_state_t;

endpackage

[hw/rtl/msort_cell.sv]
`timescale 1ns / 1ps

module msort_cell (
    input  logic                  aclk,
    input  msort_pkg::msort_ctrl_t ctrl,
    input  logic                  occupied,
    input  msort_pkg::value_t     new_value,
    input  msort_pkg::value_t     left_value,
    input  logic                  left_place,
    input  msort_pkg::value_t     right_value,
    output msort_pkg::value_t     held_value,
    output logic                  place
);

    msort_pkg::value_t held_reg;
    msort_pkg::value_t held_next;

    // An empty cell counts as larger than anything, so the new value lands
    // after every stored value that is not greater (ties keep arrival order).
    assign place = !occupied || (held_reg > new_value);

    always_comb begin
        held_next = held_reg;
        if (ctrl.load_en) begin
            if (place) begin
                held_next = left_place ? left_value : new_value;
            end
        end else if (ctrl.shift_en) begin
            held_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

    assign held_value = held_reg;

endmodule

[hw/rtl/merge_sorter_core.sv]
`timescale 1ns / 1ps

// Stable sorter for sets of up to MAX_ITEMS signed 32-bit values. Send the set
// as input beats, one value each, and mark the final beat with last; values
// that arrive once MAX_ITEMS are held are dropped, though a dropped last still
// closes the set. The set is kept in a row of MAX_ITEMS cells that stays in
// ascending order: each accepted beat is inserted as it arrives, equal values
// staying in arrival order, so loading runs at one beat per cycle. After last
// the block stops accepting input and returns the sorted set as output beats,
// smallest first, by shifting the row toward cell 0 one place per beat; the
// final output beat carries last_res. The drain waits on m_ready, and a new set
// is accepted in the cycle after the final output beat is taken.
module merge_sorter_core #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msort_pkg::s_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output msort_pkg::m_beat_t  m_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    msort_pkg::msort_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;    // values held while loading
    logic [CNT_W-1:0] remain_reg, remain_next;  // values left to return

    msort_pkg::msort_ctrl_t ctrl;
    msort_pkg::value_t      cell_value [MAX_ITEMS];
    logic                   cell_place [MAX_ITEMS];

    logic in_beat;
    logic out_beat;
    logic store_ok;

    assign s_ready  = (state_reg == msort_pkg::ST_LOAD);
    assign m_valid  = (state_reg == msort_pkg::ST_DRAIN);
    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign store_ok = (count_reg != CNT_W'(MAX_ITEMS));

    // Insert only while the row has room; shift out on each taken result.
    assign ctrl.load_en  = in_beat && store_ok;
    assign ctrl.shift_en = out_beat;

    // Row of cells; cell 0 holds the smallest value and feeds the output.
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        msort_pkg::value_t left_value;
        logic              left_place;
        msort_pkg::value_t right_value;

        if (i == 0) begin : g_head
            assign left_value = s_data.value;
            assign left_place = 1'b0;
        end else begin : g_body
            assign left_value = cell_value[i-1];
            assign left_place = cell_place[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign right_value = cell_value[i];
        end else begin : g_inner
            assign right_value = cell_value[i+1];
        end

        msort_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .new_value   (s_data.value),
            .left_value  (left_value),
            .left_place  (left_place),
            .right_value (right_value),
            .held_value  (cell_value[i]),
            .place       (cell_place[i])
        );
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        case (state_reg)
            msort_pkg::ST_LOAD: begin
                if (in_beat) begin
                    if (store_ok) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    // Close the set: count the stored values and start draining
                    if (s_data.last) begin
                        remain_next = count_next;
                        count_next  = '0;
                        state_next  = msort_pkg::ST_DRAIN;
                    end
                end
            end
            msort_pkg::ST_DRAIN: begin
                if (out_beat) begin
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = msort_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                state_next  = msort_pkg::ST_LOAD;
                count_next  = '0;
                remain_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= msort_pkg::ST_LOAD;
            count_reg  <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    assign m_data.value_res = cell_value[0];
    assign m_data.last_res  = (remain_reg == CNT_W'(1));

endmodule
